### sv/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/sie_pkg.sv
// Shared types and constants of the instruction executor.
package sie_pkg;

  localparam int unsigned MEM_DEPTH_DEF = 65536;
  localparam int unsigned NUM_REGS = 16;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_RDMEM = 2'd2,
    MODE_RDREG = 2'd3
  } mode_e;

  localparam logic [3:0] OP_ADD  = 4'h0;
  localparam logic [3:0] OP_SUB  = 4'h1;
  localparam logic [3:0] OP_AND  = 4'h2;
  localparam logic [3:0] OP_OR   = 4'h3;
  localparam logic [3:0] OP_SLL  = 4'h4;
  localparam logic [3:0] OP_SRA  = 4'h5;
  localparam logic [3:0] OP_RSVD = 4'h6;
  localparam logic [3:0] OP_BEQ  = 4'h7;
  localparam logic [3:0] OP_BGT  = 4'h8;
  localparam logic [3:0] OP_BLE  = 4'h9;
  localparam logic [3:0] OP_BNE  = 4'hA;
  localparam logic [3:0] OP_JAL  = 4'hB;
  localparam logic [3:0] OP_LW   = 4'hC;
  localparam logic [3:0] OP_SW   = 4'hD;
  localparam logic [3:0] OP_LHI  = 4'hE;
  localparam logic [3:0] OP_HALT = 4'hF;

  localparam logic [3:0] REG_IMM  = 4'd1;
  localparam logic [3:0] REG_LINK = 4'd15;

  typedef enum logic [1:0] {
    MRA_REQ,
    MRA_PC,
    MRA_PC1,
    MRA_DATA
  } mem_ra_e;

  typedef enum logic [1:0] {
    RRA_REQ,
    RRA_RS,
    RRA_RT,
    RRA_RD
  } rf_ra_e;

  typedef struct packed {
    mem_ra_e mem_ra;
    rf_ra_e  rf_ra;
    logic    clr_step;
    logic    cap_req;
    logic    load_wr;
    logic    cap_rdmem;
    logic    cap_rdreg;
    logic    ld_ir;
    logic    ld_imm;
    logic    ld_a;
    logic    ld_b;
    logic    ld_d;
    logic    mod_start;
    logic    commit;
    logic    lw_wb;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  clr_last;
    logic  halted;
    logic  mod_busy;
    logic  is_lw;
    logic  out_free;
  } sts_t;

  function automatic logic [31:0] sext16(input logic [15:0] w);
    sext16 = {{16{w[15]}}, w};
  endfunction

endpackage

### sv/sie_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sie_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### sv/sie_ctrl.sv
// Sequencing state machine of the instruction executor.
module sie_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sie_pkg::sts_t sts_i,
  output sie_pkg::cmd_t cmd_o
);
  import sie_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_RDM, S_RDR, S_F1, S_F2, S_RT, S_RD,
    S_EX, S_MS, S_MW, S_CM, S_LW, S_FIN
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    cmd = '0;
    cmd.mem_ra = MRA_PC;
    cmd.rf_ra = RRA_REQ;
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.cap_req = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.mode)
          MODE_LOAD: begin
            cmd.load_wr = 1'b1;
            state_d = S_FIN;
          end
          MODE_RDMEM: begin
            cmd.mem_ra = MRA_REQ;
            state_d = S_RDM;
          end
          MODE_RDREG: begin
            cmd.rf_ra = RRA_REQ;
            state_d = S_RDR;
          end
          default: begin
            cmd.mem_ra = MRA_PC;
            state_d = sts_i.halted ? S_FIN : S_F1;
          end
        endcase
      end
      S_RDM: begin
        cmd.cap_rdmem = 1'b1;
        state_d = S_FIN;
      end
      S_RDR: begin
        cmd.cap_rdreg = 1'b1;
        state_d = S_FIN;
      end
      S_F1: begin
        cmd.ld_ir = 1'b1;
        cmd.mem_ra = MRA_PC1;
        state_d = S_F2;
      end
      S_F2: begin
        cmd.ld_imm = 1'b1;
        cmd.rf_ra = RRA_RS;
        state_d = S_RT;
      end
      S_RT: begin
        cmd.ld_a = 1'b1;
        cmd.rf_ra = RRA_RT;
        state_d = S_RD;
      end
      S_RD: begin
        cmd.ld_b = 1'b1;
        cmd.rf_ra = RRA_RD;
        state_d = S_EX;
      end
      S_EX: begin
        cmd.ld_d = 1'b1;
        state_d = S_MS;
      end
      S_MS: begin
        cmd.mod_start = 1'b1;
        state_d = S_MW;
      end
      S_MW: begin
        if (!sts_i.mod_busy) state_d = S_CM;
      end
      S_CM: begin
        cmd.commit = 1'b1;
        cmd.mem_ra = MRA_DATA;
        state_d = sts_i.is_lw ? S_LW : S_FIN;
      end
      S_LW: begin
        cmd.lw_wb = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;
  assign in_stall_o = (state_q != S_IDLE);
endmodule

### sv/sie_dpath.sv
// Datapath: word store, register file, program counter, ALU and address modulo unit.
module sie_dpath #(
  parameter int unsigned MEM_DEPTH = sie_pkg::MEM_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sie_pkg::cmd_t        cmd_i,
  output sie_pkg::sts_t        sts_o,
  input  sie_pkg::mode_e       mode_i,
  input  logic [15:0]          address_i,
  input  logic [15:0]          data_i,
  input  logic [3:0]           reg_index_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic signed [31:0]   read_data_o,
  output logic [15:0]          pc_now_o,
  output logic                 halted_o,
  output logic [31:0]          executed_count_o
);
  import sie_pkg::*;

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam bit POW2 = ((MEM_DEPTH & (MEM_DEPTH - 1)) == 0);
  localparam logic [16:0] DEPTH17 = 17'(MEM_DEPTH);
  localparam logic [AW:0] DEPTHW = (AW + 1)'(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);
  // ceil(2^32 / depth): exact quotient for any 16-bit dividend
  localparam logic [63:0] RECIP64 =
    ((64'd1 << 32) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH);
  localparam logic [24:0] RECIP = RECIP64[24:0];

  // request
  mode_e       req_mode_q;
  logic [15:0] req_addr_q, req_data_q;
  logic [3:0]  req_ri_q;

  // architectural state
  logic [AW-1:0] pc_q, clr_q;
  logic [AW:0]   used_q;
  logic          stop_q;
  logic [31:0]   count_q;
  logic [NUM_REGS-1:0] rf_vld_q;

  // instruction
  logic [15:0] ir_q;
  logic [31:0] imm_q, a_q, b_q, d_q, res_q;
  logic [3:0]  op, fd, fs, ft;
  logic        two;

  // modulo unit
  logic          mod_busy_q;
  logic [4:0]    mod_cnt_q;
  logic [15:0]   mod_sh_q;
  logic [7:0]    mod_quo_q;
  logic [AW-1:0] mod_r_q;
  logic [40:0]   mod_prod;
  logic [24:0]   mod_qd;
  logic [16:0]   mod_rem;
  logic [15:0]   mod_x;

  // memories
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;
  logic          rf_we;
  logic [3:0]    rf_waddr, rf_raddr;
  logic [31:0]   rf_wdata, rf_rdata, rf_val;
  logic          rf_vld_rd_q;

  // output
  logic        out_valid_q, halted_out_q;
  logic [31:0] rdata_out_q, count_out_q;
  logic [15:0] pc_out_q;

  logic          addr_ok, halted_now, take;
  logic [AW:0]   pc_inc, pc1_sum, seq_sum;
  logic [AW-1:0] pc1, seq_pc;
  logic [AW:0]   sw_end;
  logic [31:0]   alu, sum_ab;

  assign op = ir_q[15:12];
  assign fd = ir_q[11:8];
  assign fs = ir_q[7:4];
  assign ft = ir_q[3:0];
  assign two = (fd == REG_IMM) || (fs == REG_IMM) || (ft == REG_IMM);

  assign addr_ok = {1'b0, req_addr_q} < DEPTH17;
  assign halted_now = stop_q || ({1'b0, pc_q} >= used_q);

  assign pc1_sum = {1'b0, pc_q} + (AW + 1)'(1);
  assign pc1 = (pc1_sum >= DEPTHW) ? AW'(pc1_sum - DEPTHW) : pc1_sum[AW-1:0];
  assign pc_inc = two ? (AW + 1)'(2) : (AW + 1)'(1);
  assign seq_sum = {1'b0, pc_q} + pc_inc;
  assign seq_pc = (seq_sum >= DEPTHW) ? AW'(seq_sum - DEPTHW) : seq_sum[AW-1:0];
  assign sw_end = {1'b0, mod_r_q} + (AW + 1)'(1);

  assign rf_val = rf_vld_rd_q ? rf_rdata : 32'd0;
  assign sum_ab = a_q + b_q;

  always_comb begin
    case (op)
      OP_JAL, OP_BEQ, OP_BGT, OP_BLE, OP_BNE: mod_x = d_q[15:0];
      default:                                mod_x = sum_ab[15:0];
    endcase
  end

  always_comb begin
    case (op)
      OP_ADD: alu = sum_ab;
      OP_SUB: alu = a_q - b_q;
      OP_AND: alu = a_q & b_q;
      OP_OR:  alu = a_q | b_q;
      OP_SLL: alu = (b_q >= 32'd32) ? 32'd0 : (a_q << b_q[4:0]);
      OP_SRA: alu = (b_q >= 32'd32) ? {32{a_q[31]}} : 32'($signed(a_q) >>> b_q[4:0]);
      OP_LHI: alu = {a_q[15:0], d_q[15:0]};
      default: alu = {16'd0, 16'(pc_q) + (two ? 16'd2 : 16'd1)};
    endcase
  end

  always_comb begin
    case (op)
      OP_BEQ:  take = (a_q == b_q);
      OP_BGT:  take = ($signed(a_q) > $signed(b_q));
      OP_BLE:  take = ($signed(a_q) <= $signed(b_q));
      OP_BNE:  take = (a_q != b_q);
      default: take = 1'b0;
    endcase
  end

  // word store ports
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 16'd0;
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.load_wr) begin
      mem_we = addr_ok;
      mem_waddr = req_addr_q[AW-1:0];
      mem_wdata = req_data_q;
    end else if (cmd_i.commit && (op == OP_SW)) begin
      mem_we = 1'b1;
      mem_waddr = mod_r_q;
      mem_wdata = d_q[15:0];
    end
    case (cmd_i.mem_ra)
      MRA_REQ:  mem_raddr = req_addr_q[AW-1:0];
      MRA_PC1:  mem_raddr = pc1;
      MRA_DATA: mem_raddr = mod_r_q;
      default:  mem_raddr = pc_q;
    endcase
  end

  // register file ports
  always_comb begin
    rf_we = 1'b0;
    rf_waddr = fd;
    rf_wdata = alu;
    if (cmd_i.lw_wb) begin
      rf_we = (fd != REG_IMM);
      rf_wdata = sext16(mem_rdata);
    end else if (cmd_i.commit) begin
      case (op)
        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLL, OP_SRA, OP_LHI: rf_we = (fd != REG_IMM);
        OP_JAL: begin
          rf_we = 1'b1;
          rf_waddr = REG_LINK;
        end
        default: rf_we = 1'b0;
      endcase
    end
    case (cmd_i.rf_ra)
      RRA_RS:  rf_raddr = fs;
      RRA_RT:  rf_raddr = ft;
      RRA_RD:  rf_raddr = fd;
      default: rf_raddr = req_ri_q;
    endcase
  end

  sie_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sie_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  // quotient by reciprocal, then remainder
  assign mod_prod = {25'd0, mod_sh_q} * {16'd0, RECIP};
  assign mod_qd = {17'd0, mod_quo_q} * {8'd0, DEPTH17};
  assign mod_rem = {1'b0, mod_sh_q} - mod_qd[16:0];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      clr_q <= '0;
      used_q <= '0;
      stop_q <= 1'b0;
      count_q <= '0;
      rf_vld_q <= '0;
      rf_vld_rd_q <= 1'b0;
      mod_busy_q <= 1'b0;
      mod_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + AW'(1);
      rf_vld_rd_q <= rf_vld_q[rf_raddr];
      if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
      if (cmd_i.load_wr && addr_ok && (used_q < {1'b0, req_addr_q[AW-1:0]} + (AW + 1)'(1))) begin
        used_q <= {1'b0, req_addr_q[AW-1:0]} + (AW + 1)'(1);
      end
      if (cmd_i.mod_start) begin
        mod_busy_q <= !POW2;
        mod_cnt_q <= 5'd2;
      end else if (mod_busy_q) begin
        mod_cnt_q <= mod_cnt_q - 5'd1;
        mod_busy_q <= (mod_cnt_q != 5'd1);
      end
      if (cmd_i.commit) begin
        if (count_q != 32'hFFFF_FFFF) count_q <= count_q + 32'd1;
        case (op)
          OP_BEQ, OP_BGT, OP_BLE, OP_BNE: pc_q <= take ? mod_r_q : seq_pc;
          OP_JAL: pc_q <= mod_r_q;
          OP_HALT: stop_q <= 1'b1;
          OP_SW: begin
            pc_q <= seq_pc;
            if (used_q < sw_end) used_q <= sw_end;
          end
          default: pc_q <= seq_pc;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req) begin
      req_mode_q <= mode_i;
      req_addr_q <= address_i;
      req_data_q <= data_i;
      req_ri_q <= reg_index_i;
      res_q <= 32'd0;
    end
    if (cmd_i.cap_rdmem) res_q <= addr_ok ? sext16(mem_rdata) : 32'd0;
    if (cmd_i.cap_rdreg) res_q <= rf_val;
    if (cmd_i.ld_ir) ir_q <= mem_rdata;
    if (cmd_i.ld_imm) imm_q <= sext16(mem_rdata);
    if (cmd_i.ld_a) a_q <= (fs == REG_IMM) ? imm_q : rf_val;
    if (cmd_i.ld_b) b_q <= (ft == REG_IMM) ? imm_q : rf_val;
    if (cmd_i.ld_d) d_q <= (fd == REG_IMM) ? imm_q : rf_val;
    if (cmd_i.mod_start) begin
      if (POW2) begin
        mod_r_q <= mod_x[AW-1:0];
      end else begin
        mod_r_q <= '0;
      end
      mod_sh_q <= mod_x;
    end else if (mod_busy_q) begin
      if (mod_cnt_q == 5'd2) begin
        mod_quo_q <= mod_prod[39:32];
      end else begin
        mod_r_q <= mod_rem[AW-1:0];
      end
    end
    if (cmd_i.out_load) begin
      rdata_out_q <= res_q;
      pc_out_q <= 16'(pc_q);
      halted_out_q <= halted_now;
      count_out_q <= count_q;
    end
  end

  assign sts_o.mode = req_mode_q;
  assign sts_o.clr_last = (clr_q == LAST_ADDR);
  assign sts_o.halted = halted_now;
  assign sts_o.mod_busy = mod_busy_q;
  assign sts_o.is_lw = (op == OP_LW);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign read_data_o = $signed(rdata_out_q);
  assign pc_now_o = pc_out_q;
  assign halted_o = halted_out_q;
  assign executed_count_o = count_out_q;
endmodule

### sv/simple_isa_instruction_executor_top.sv
// Top level of the simple instruction executor: controller plus datapath.
// After reset the block clears its whole word store, one word per cycle, before it takes
// the first request. A load is captured and written; a memory or register read waits for
// the registered read data. An instruction fetches its word and immediate, reads three
// operands, executes, forms its address and commits (lw adds a write-back); when
// MEM_DEPTH is not a power of two it also waits for the modulo unit. The steps follow
// from the single read ports of the word store and register file, walked one access per
// cycle. A finished result waits in the output register while the next request is taken.
module simple_isa_instruction_executor_top #(
  parameter int unsigned MEM_DEPTH = sie_pkg::MEM_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [15:0]         address_i,
  input  logic [15:0]         data_i,
  input  logic [3:0]          reg_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  read_data_o,
  output logic [15:0]         pc_now_o,
  output logic                halted_o,
  output logic [31:0]         executed_count_o
);
  import sie_pkg::*;
  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  sie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sie_dpath #(.MEM_DEPTH(MEM_DEPTH)) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_e'(mode_i)),
    .address_i        (address_i),
    .data_i           (data_i),
    .reg_index_i      (reg_index_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .read_data_o      (read_data_o),
    .pc_now_o         (pc_now_o),
    .halted_o         (halted_o),
    .executed_count_o (executed_count_o)
  );

  `ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPL(a_mod_idle_at_start, cmd.mod_start, !sts.mod_busy)
  `ASSERT_IMPL(a_mod_done_at_commit, cmd.commit, !sts.mod_busy)
endmodule

### test/tb_simple_isa_instruction_executor_top.sv
// Testbench for the simple instruction executor: directed table plus random programs.
`timescale 1ns / 100ps
module tb_simple_isa_instruction_executor_top;
  import sie_pkg::*;

  localparam int unsigned DEPTH = 65536;
  localparam int unsigned LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [15:0] data;
    logic [3:0]  reg_index;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pc_now;
    logic        halted;
    logic [31:0] executed_count;
  } rsp_t;

  typedef struct packed {
    req_t req;
    logic known;
    rsp_t rsp;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [15:0] address_i;
  logic [15:0] data_i;
  logic [3:0]  reg_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [31:0] read_data_o;
  logic [15:0] pc_now_o;
  logic        halted_o;
  logic [31:0] executed_count_o;

  simple_isa_instruction_executor_top u_dut (.*);

  // predictor state
  logic [31:0] regs [16];
  logic [15:0] mem [DEPTH];
  logic [15:0] pc;
  logic        stopped;
  logic [31:0] total;
  logic [16:0] used;

  rsp_t expected_q [$];
  int   errors;
  int   mismatches;
  int   cycles;
  bit   quiet;

  function automatic logic [31:0] sx(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] operand(input logic [3:0] f, input logic [31:0] imm);
    return (f == REG_IMM) ? imm : regs[f];
  endfunction

  function automatic void write_reg(input logic [3:0] f, input logic [31:0] v);
    if (f != REG_IMM) regs[f] = v;
  endfunction

  function automatic void run_instruction();
    logic [15:0] w, nxt, addr;
    logic [3:0]  op, rd, rs, rt;
    logic        two, take;
    logic [31:0] imm, a, b, d;
    w = mem[pc];
    op = w[15:12]; rd = w[11:8]; rs = w[7:4]; rt = w[3:0];
    two = (rd == REG_IMM) || (rs == REG_IMM) || (rt == REG_IMM);
    imm = two ? sx(mem[16'(pc + 16'd1)]) : 32'd0;
    a = operand(rs, imm); b = operand(rt, imm); d = operand(rd, imm);
    nxt = pc + (two ? 16'd2 : 16'd1);
    take = 1'b0;
    if (total != 32'hFFFF_FFFF) total++;
    case (op)
      OP_ADD: write_reg(rd, a + b);
      OP_SUB: write_reg(rd, a - b);
      OP_AND: write_reg(rd, a & b);
      OP_OR:  write_reg(rd, a | b);
      OP_SLL: write_reg(rd, (b >= 32) ? 32'd0 : a << b[4:0]);
      OP_SRA: write_reg(rd, (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]));
      OP_BEQ: take = (a == b);
      OP_BGT: take = ($signed(a) > $signed(b));
      OP_BLE: take = ($signed(a) <= $signed(b));
      OP_BNE: take = (a != b);
      OP_JAL: begin
        regs[REG_LINK] = {16'd0, nxt};
        nxt = d[15:0];
      end
      OP_LW: write_reg(rd, sx(mem[16'(a + b)]));
      OP_SW: begin
        addr = 16'(a + b);
        mem[addr] = d[15:0];
        if (used < {1'b0, addr} + 17'd1) used = {1'b0, addr} + 17'd1;
      end
      OP_LHI: write_reg(rd, {a[15:0], regs[rd][15:0]});
      OP_HALT: begin
        stopped = 1'b1;
        nxt = pc;
      end
      default: ;
    endcase
    if (take) nxt = d[15:0];
    pc = nxt;
  endfunction

  function automatic rsp_t predict_step(input req_t r);
    rsp_t o;
    o.read_data = 32'd0;
    case (r.mode)
      MODE_LOAD: begin
        mem[r.address] = r.data;
        if (used < {1'b0, r.address} + 17'd1) used = {1'b0, r.address} + 17'd1;
      end
      MODE_EXEC: if (!(stopped || {1'b0, pc} >= used)) run_instruction();
      MODE_RDMEM: o.read_data = sx(mem[r.address]);
      default: o.read_data = regs[r.reg_index];
    endcase
    o.pc_now = pc;
    o.halted = stopped || ({1'b0, pc} >= used);
    o.executed_count = total;
    return o;
  endfunction

  function automatic req_t mk(input logic [1:0] m, input logic [15:0] a,
                              input logic [15:0] dt, input logic [3:0] ri);
    req_t r;
    r.mode = m; r.address = a; r.data = dt; r.reg_index = ri;
    return r;
  endfunction

  function automatic logic [15:0] iw(input logic [3:0] op, input logic [3:0] rd,
                                     input logic [3:0] rs, input logic [3:0] rt);
    return {op, rd, rs, rt};
  endfunction

  // clock and reset
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // response side
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result");
        end else begin
          rsp_t e;
          e = expected_q.pop_front();
          if (e.read_data !== read_data_o || e.pc_now !== pc_now_o ||
              e.halted !== halted_o || e.executed_count !== executed_count_o) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch exp rd=%h pc=%h h=%b n=%h got rd=%h pc=%h h=%b n=%h",
                       e.read_data, e.pc_now, e.halted, e.executed_count,
                       read_data_o, pc_now_o, halted_o, executed_count_o);
          end
        end
      end
      out_stall_i <= (!quiet && $urandom_range(99) < 12);
    end
  end

  task automatic send(input req_t r, input bit known, input rsp_t ex);
    rsp_t p;
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= r.mode;
    address_i   <= r.address;
    data_i      <= r.data;
    reg_index_i <= r.reg_index;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = predict_step(r);
    if (known && p !== ex) begin
      errors++;
      if (mismatches++ < 10) $display("table row disagrees with predictor");
    end
    expected_q.push_back(p);
  endtask

  task automatic send_free(input req_t r);
    send(r, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // random program: loads then a run of mostly executes with some memory and register reads
  task automatic random_program(input int n);
    logic [3:0]  op, rd, rs, rt;
    logic [15:0] base;
    base = (($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(63)));
    for (int k = 0; k < n; k++) begin
      op = 4'($urandom); rd = 4'($urandom); rs = 4'($urandom); rt = 4'($urandom);
      if (op == OP_HALT && $urandom_range(3) != 0) op = OP_ADD;
      if (op >= OP_BEQ && op <= OP_JAL && $urandom_range(1)) rd = REG_IMM;
      send_free(mk(MODE_LOAD, 16'(base + k),
                   ($urandom_range(9) == 0) ? 16'($urandom) : iw(op, rd, rs, rt), 4'd0));
      if ($urandom_range(2) == 0)
        send_free(mk(MODE_LOAD, 16'(base + k + 1), 16'($urandom_range(40)), 4'd0));
    end
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: send_free(mk(MODE_RDMEM, 16'($urandom), 16'($urandom), 4'($urandom)));
        1: send_free(mk(MODE_RDREG, 16'($urandom), 16'($urandom), 4'($urandom)));
        default: send_free(mk(MODE_EXEC, 16'($urandom), 16'($urandom), 4'($urandom)));
      endcase
    end
  endtask

  row_t table_rows [$];

  task automatic add_row(input req_t r, input bit k, input rsp_t e);
    row_t t;
    t.req = r; t.known = k; t.rsp = e;
    table_rows.push_back(t);
  endtask

  initial begin
    in_valid_i = 1'b0; mode_i = '0; address_i = '0; data_i = '0; reg_index_i = '0;
    errors = 0; mismatches = 0; cycles = 0; quiet = 1'b0;
    foreach (regs[i]) regs[i] = '0;
    foreach (mem[i]) mem[i] = '0;
    pc = '0; stopped = 1'b0; total = '0; used = '0;

    // after reset: halted, nothing executes; then a load and read back at the top address
    add_row(mk(MODE_RDREG, 16'hFFFF, 16'hFFFF, 4'd15), 1, {32'd0, 16'd0, 1'b1, 32'd0});
    add_row(mk(MODE_EXEC, 16'd0, 16'd0, 4'd0), 1, {32'd0, 16'd0, 1'b1, 32'd0});
    add_row(mk(MODE_LOAD, 16'hFFFF, 16'h8000, 4'd0), 1, {32'd0, 16'd0, 1'b0, 32'd0});
    add_row(mk(MODE_RDMEM, 16'hFFFF, 16'd0, 4'd0), 1,
            {32'hFFFF_8000, 16'd0, 1'b0, 32'd0});
    // program: imm ops, rd one dropped, reserved, sra, lhi, sw, jal, halt
    add_row(mk(MODE_LOAD, 16'd0, iw(OP_ADD, 4'd2, REG_IMM, REG_IMM), 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd1, 16'hFFFF, 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd2, iw(OP_ADD, REG_IMM, 4'd2, 4'd2), 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd3, 16'h0005, 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd4, iw(OP_RSVD, 4'd3, 4'd2, 4'd2), 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd5, iw(OP_SRA, 4'd3, 4'd2, REG_IMM), 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd6, 16'h0040, 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd7, iw(OP_LHI, 4'd0, REG_IMM, 4'd0), 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd8, 16'h7FFF, 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd9, iw(OP_SW, 4'd0, REG_IMM, 4'd2), 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd10, 16'h0020, 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd11, iw(OP_JAL, REG_IMM, 4'd0, 4'd0), 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd12, 16'd14, 4'd0), 0, '0);
    add_row(mk(MODE_LOAD, 16'd14, iw(OP_HALT, 4'd0, 4'd0, 4'd0), 4'd0), 0, '0);
    for (int k = 0; k < 8; k++) add_row(mk(MODE_EXEC, 16'd0, 16'd0, 4'd0), 0, '0);
    add_row(mk(MODE_RDREG, 16'd0, 16'd0, 4'd15), 0, '0);

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    foreach (table_rows[i]) send(table_rows[i].req, table_rows[i].known, table_rows[i].rsp);

    // hold off until everything is back
    drain();

    for (int blk = 0; blk < 40; blk++) begin
      quiet = (blk >= 15 && blk < 20);
      // fresh program at a random base; pc continues and a stop is not cleared
      random_program($urandom_range(4, 10));
      for (int k = 0; k < 2; k++)
        send_free(mk(2'($urandom), 16'($urandom), 16'($urandom), 4'($urandom)));
    end
    quiet = 1'b0;
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
